// ===== rtl/ahw_pkg.sv =====
// Package for the adaptive heartbeat watchdog.
// Holds port widths, default parameter values, register indexes and the
// command and status structs that join the controller and the datapath.
package ahw_pkg;

   localparam int TIME_W            = 64;
   localparam int BEAT_W            = 17;
   localparam int STAT_W            = 24;
   localparam int INTERVAL_BITS_DEF = 24;
   localparam int COUNT_BITS_DEF    = 16;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 8;
   localparam int FACTOR_W          = 4;
   localparam int MIN_W             = 8;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd3;
   localparam logic [MIN_W-1:0]    MIN_RESET    = 8'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVIATION_FACTOR = 1'b0,
      CSR_MIN_INTERVALS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic square;
      logic update;
      logic setup;
      logic mult_step;
      logic mean_step;
      logic diff;
      logic div_step;
      logic root_step;
      logic store;
      logic scale;
      logic deadline;
      logic emit;
   } ahw_cmd_type;

   typedef struct packed {
      logic item_check;
      logic item_reject;
      logic stat_room;
      logic rsp_free;
   } ahw_status_type;

endpackage

// ===== rtl/ahw_ctrl.sv =====
// Controller state machine of the adaptive heartbeat watchdog.
// Sequences the datapath through evaluate, update, multiply, divide, root, deadline and result phases.
// Depends on ahw_pkg for the command and status structs.
module ahw_ctrl #(
   parameter int INTERVAL_BITS = ahw_pkg::INTERVAL_BITS_DEF,
   parameter int COUNT_BITS    = ahw_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ahw_pkg::ahw_status_type status,
   output ahw_pkg::ahw_cmd_type    cmd
);
   import ahw_pkg::*;

   localparam int SUM_W      = INTERVAL_BITS + COUNT_BITS;
   localparam int DIV_STEPS  = 2 * INTERVAL_BITS;
   localparam int ROOT_STEPS = INTERVAL_BITS;
   localparam int STEPS_MAX  = (SUM_W > DIV_STEPS) ? SUM_W : DIV_STEPS;
   localparam int STEP_W     = $clog2(STEPS_MAX);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_EVAL     = 13'b0000000000010,
      ST_SQUARE   = 13'b0000000000100,
      ST_UPDATE   = 13'b0000000001000,
      ST_SETUP    = 13'b0000000010000,
      ST_MULT     = 13'b0000000100000,
      ST_DIFF     = 13'b0000001000000,
      ST_DIVIDE   = 13'b0000010000000,
      ST_ROOT     = 13'b0000100000000,
      ST_STORE    = 13'b0001000000000,
      ST_SCALE    = 13'b0010000000000,
      ST_DEADLINE = 13'b0100000000000,
      ST_EMIT     = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                accept;

   assign req_stall = (state_ff != ST_IDLE) || reset;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.item_check || status.item_reject) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.stat_room) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = STEP_W'(SUM_W - 1);
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_step = 1'b1;
            cmd.mean_step = (cnt_ff >= STEP_W'(COUNT_BITS));
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = STEP_W'(DIV_STEPS - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = STEP_W'(ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DEADLINE;
         end
         ST_DEADLINE: begin
            cmd.deadline = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EVAL))
      else $error("accepted transfer did not start evaluation");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !status.rsp_free |=> (state_ff == ST_EMIT))
      else $error("result dropped while the output register was full");

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (cnt_ff < STEP_W'(ROOT_STEPS)))
      else $error("root step counter out of range");

endmodule

// ===== rtl/ahw_datapath.sv =====
// Datapath of the adaptive heartbeat watchdog: interval statistics,
// serial multipliers, restoring dividers, digit square root and the result
// register. Depends on ahw_pkg and is driven by ahw_ctrl.
module ahw_datapath #(
   parameter int INTERVAL_BITS = ahw_pkg::INTERVAL_BITS_DEF,
   parameter int COUNT_BITS    = ahw_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ahw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ahw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_action,
   input  logic [ahw_pkg::TIME_W-1:0]          req_time_now,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_rejected,
   output logic                                rsp_is_expired,
   output logic                                rsp_deadline_valid,
   output logic [ahw_pkg::TIME_W-1:0]          rsp_deadline_time,
   output logic [ahw_pkg::BEAT_W-1:0]          rsp_beat_count,
   output logic [ahw_pkg::STAT_W-1:0]          rsp_mean_interval,
   output logic [ahw_pkg::STAT_W-1:0]          rsp_interval_deviation,
   input  ahw_pkg::ahw_cmd_type                cmd,
   output ahw_pkg::ahw_status_type             status
);
   import ahw_pkg::*;

   localparam int IV_W   = INTERVAL_BITS;
   localparam int CNT_W  = COUNT_BITS;
   localparam int SUM_W  = IV_W + CNT_W;
   localparam int SQ_W   = 2 * IV_W + CNT_W;
   localparam int PROD_W = 2 * IV_W + 2 * CNT_W;
   localparam int Q_W    = 2 * IV_W;
   localparam int NSQ_W  = 2 * CNT_W;
   localparam int KDEV_W = IV_W + FACTOR_W;
   localparam int OFF_W  = KDEV_W + 1;
   localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   // Configuration.
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [MIN_W-1:0]    min_int_ff, min_int_in;

   // Item under work.
   logic                action_ff, action_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                reject_ff, reject_in;

   // Watchdog state.
   logic [TIME_W-1:0]   last_ff, last_in;
   logic                have_ff, have_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]     sumsq_ff, sumsq_in;
   logic [TIME_W-1:0]   deadline_ff, deadline_in;
   logic                dl_set_ff, dl_set_in;
   logic [IV_W-1:0]     mean_ff, mean_in;
   logic [IV_W-1:0]     dev_ff, dev_in;

   // Working registers.
   logic [IV_W-1:0]     iv_ff, iv_in;
   logic [Q_W-1:0]      sq_ff, sq_in;
   logic [PROD_W-1:0]   acc1_ff, acc1_in, mcand1_ff, mcand1_in;
   logic [CNT_W-1:0]    mplier1_ff, mplier1_in;
   logic [PROD_W-1:0]   acc2_ff, acc2_in, mcand2_ff, mcand2_in;
   logic [SUM_W-1:0]    mplier2_ff, mplier2_in;
   logic [NSQ_W-1:0]    nsq_ff, nsq_in;
   logic [CNT_W-1:0]    mrem_ff, mrem_in;
   logic [IV_W-1:0]     mquo_ff, mquo_in;
   logic [NSQ_W-1:0]    rem_ff, rem_in;
   logic [Q_W-1:0]      dvd_ff, dvd_in;
   logic [IV_W:0]       srem_ff, srem_in;
   logic [IV_W-1:0]     root_ff, root_in;
   logic [KDEV_W-1:0]   kdev_ff, kdev_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_rejected_ff, rsp_rejected_in;
   logic                rsp_expired_ff, rsp_expired_in;
   logic                rsp_dl_valid_ff, rsp_dl_valid_in;
   logic [TIME_W-1:0]   rsp_dl_time_ff, rsp_dl_time_in;
   logic [BEAT_W-1:0]   rsp_beats_ff, rsp_beats_in;
   logic [STAT_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [STAT_W-1:0]   rsp_dev_ff, rsp_dev_in;

   // Combinational helpers.
   logic [TIME_W-1:0]   gap;
   logic [CNT_W:0]      mrem_sh;
   logic [NSQ_W:0]      rem_sh;
   logic [PROD_W:0]     num_diff;
   logic [IV_W+2:0]     srem_sh;
   logic [IV_W+2:0]     trial;
   logic [OFF_W-1:0]    offset;
   logic [TIME_W:0]     dl_sum;
   logic [CMP_W-1:0]    need;

   assign gap      = time_ff - last_ff;
   assign mrem_sh  = {mrem_ff, mquo_ff[IV_W-1]};
   assign rem_sh   = {rem_ff, dvd_ff[Q_W-1]};
   assign num_diff = {1'b0, acc1_ff} - {1'b0, acc2_ff};
   assign srem_sh  = {srem_ff, dvd_ff[Q_W-1:Q_W-2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign offset   = OFF_W'(mean_ff) + OFF_W'(kdev_ff);
   assign dl_sum   = {1'b0, last_ff} + (TIME_W + 1)'(offset);
   assign need     = (min_int_ff == '0) ? CMP_W'(1) : CMP_W'(min_int_ff);

   assign status.item_check  = action_ff;
   assign status.item_reject = !action_ff && have_ff && (time_ff < last_ff);
   assign status.stat_room   = have_ff && (count_ff != '1);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      factor_in  = factor_ff;
      min_int_in = min_int_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEVIATION_FACTOR: factor_in  = csr_wdata[FACTOR_W-1:0];
            CSR_MIN_INTERVALS:    min_int_in = csr_wdata[MIN_W-1:0];
            default: begin
               factor_in  = factor_ff;
               min_int_in = min_int_ff;
            end
         endcase
      end
   end

   always_comb begin
      action_in   = action_ff;
      time_in     = time_ff;
      reject_in   = reject_ff;
      last_in     = last_ff;
      have_in     = have_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      sumsq_in    = sumsq_ff;
      deadline_in = deadline_ff;
      dl_set_in   = dl_set_ff;
      mean_in     = mean_ff;
      dev_in      = dev_ff;
      iv_in       = iv_ff;
      sq_in       = sq_ff;
      acc1_in     = acc1_ff;
      mcand1_in   = mcand1_ff;
      mplier1_in  = mplier1_ff;
      acc2_in     = acc2_ff;
      mcand2_in   = mcand2_ff;
      mplier2_in  = mplier2_ff;
      nsq_in      = nsq_ff;
      mrem_in     = mrem_ff;
      mquo_in     = mquo_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      kdev_in     = kdev_ff;

      if (cmd.capture) begin
         action_in = req_action;
         time_in   = req_time_now;
      end
      if (cmd.eval) begin
         reject_in = status.item_reject;
         if (gap[TIME_W-1:IV_W] != '0) begin
            iv_in = '1;
         end else begin
            iv_in = gap[IV_W-1:0];
         end
      end
      if (cmd.square) begin
         sq_in = Q_W'(iv_ff) * Q_W'(iv_ff);
      end
      if (cmd.update) begin
         if (status.stat_room) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(iv_ff);
            sumsq_in = sumsq_ff + SQ_W'(sq_ff);
         end
         last_in = time_ff;
         have_in = 1'b1;
      end
      if (cmd.setup) begin
         acc1_in    = '0;
         mcand1_in  = PROD_W'(sumsq_ff);
         mplier1_in = count_ff;
         acc2_in    = '0;
         mcand2_in  = PROD_W'(sum_ff);
         mplier2_in = sum_ff;
         nsq_in     = NSQ_W'(count_ff) * NSQ_W'(count_ff);
         mrem_in    = sum_ff[SUM_W-1:IV_W];
         mquo_in    = sum_ff[IV_W-1:0];
      end
      if (cmd.mult_step) begin
         if (mplier1_ff[0]) begin
            acc1_in = acc1_ff + mcand1_ff;
         end
         mcand1_in  = {mcand1_ff[PROD_W-2:0], 1'b0};
         mplier1_in = {1'b0, mplier1_ff[CNT_W-1:1]};
         if (mplier2_ff[0]) begin
            acc2_in = acc2_ff + mcand2_ff;
         end
         mcand2_in  = {mcand2_ff[PROD_W-2:0], 1'b0};
         mplier2_in = {1'b0, mplier2_ff[SUM_W-1:1]};
      end
      if (cmd.mean_step) begin
         if (mrem_sh >= {1'b0, count_ff}) begin
            mrem_in = CNT_W'(mrem_sh - {1'b0, count_ff});
            mquo_in = {mquo_ff[IV_W-2:0], 1'b1};
         end else begin
            mrem_in = mrem_sh[CNT_W-1:0];
            mquo_in = {mquo_ff[IV_W-2:0], 1'b0};
         end
      end
      if (cmd.diff) begin
         if (num_diff[PROD_W]) begin
            rem_in = '0;
            dvd_in = '0;
         end else begin
            rem_in = num_diff[PROD_W-1:Q_W];
            dvd_in = num_diff[Q_W-1:0];
         end
         srem_in = '0;
         root_in = '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, nsq_ff}) begin
            rem_in = NSQ_W'(rem_sh - {1'b0, nsq_ff});
            dvd_in = {dvd_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[NSQ_W-1:0];
            dvd_in = {dvd_ff[Q_W-2:0], 1'b0};
         end
      end
      if (cmd.root_step) begin
         dvd_in = {dvd_ff[Q_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_in = (IV_W + 1)'(srem_sh - trial);
            root_in = {root_ff[IV_W-2:0], 1'b1};
         end else begin
            srem_in = srem_sh[IV_W:0];
            root_in = {root_ff[IV_W-2:0], 1'b0};
         end
      end
      if (cmd.store) begin
         mean_in = mquo_ff;
         dev_in  = root_ff;
      end
      if (cmd.scale) begin
         kdev_in = KDEV_W'(factor_ff) * KDEV_W'(dev_ff);
      end
      if (cmd.deadline && (CMP_W'(count_ff) >= need)) begin
         if (dl_sum[TIME_W]) begin
            deadline_in = '1;
         end else begin
            deadline_in = dl_sum[TIME_W-1:0];
         end
         dl_set_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_expired_in  = rsp_expired_ff;
      rsp_dl_valid_in = rsp_dl_valid_ff;
      rsp_dl_time_in  = rsp_dl_time_ff;
      rsp_beats_in    = rsp_beats_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_dev_in      = rsp_dev_ff;
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_rejected_in = reject_ff;
         rsp_expired_in  = action_ff && dl_set_ff && (time_ff > deadline_ff);
         rsp_dl_valid_in = dl_set_ff;
         rsp_dl_time_in  = deadline_ff;
         if (count_ff != '0) begin
            rsp_beats_in = BEAT_W'(count_ff) + 1'b1;
         end else begin
            rsp_beats_in = BEAT_W'(have_ff);
         end
         rsp_mean_in = STAT_W'(mean_ff);
         rsp_dev_in  = STAT_W'(dev_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_RESET;
         min_int_ff   <= MIN_RESET;
         last_ff      <= '0;
         have_ff      <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         deadline_ff  <= '0;
         dl_set_ff    <= 1'b0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         factor_ff    <= factor_in;
         min_int_ff   <= min_int_in;
         last_ff      <= last_in;
         have_ff      <= have_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         deadline_ff  <= deadline_in;
         dl_set_ff    <= dl_set_in;
         mean_ff      <= mean_in;
         dev_ff       <= dev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      time_ff         <= time_in;
      reject_ff       <= reject_in;
      iv_ff           <= iv_in;
      sq_ff           <= sq_in;
      acc1_ff         <= acc1_in;
      mcand1_ff       <= mcand1_in;
      mplier1_ff      <= mplier1_in;
      acc2_ff         <= acc2_in;
      mcand2_ff       <= mcand2_in;
      mplier2_ff      <= mplier2_in;
      nsq_ff          <= nsq_in;
      mrem_ff         <= mrem_in;
      mquo_ff         <= mquo_in;
      rem_ff          <= rem_in;
      dvd_ff          <= dvd_in;
      srem_ff         <= srem_in;
      root_ff         <= root_in;
      kdev_ff         <= kdev_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_expired_ff  <= rsp_expired_in;
      rsp_dl_valid_ff <= rsp_dl_valid_in;
      rsp_dl_time_ff  <= rsp_dl_time_in;
      rsp_beats_ff    <= rsp_beats_in;
      rsp_mean_ff     <= rsp_mean_in;
      rsp_dev_ff      <= rsp_dev_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_rejected           = rsp_rejected_ff;
   assign rsp_is_expired         = rsp_expired_ff;
   assign rsp_deadline_valid     = rsp_dl_valid_ff;
   assign rsp_deadline_time      = rsp_dl_time_ff;
   assign rsp_beat_count         = rsp_beats_ff;
   assign rsp_mean_interval      = rsp_mean_ff;
   assign rsp_interval_deviation = rsp_dev_ff;

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten before its transfer");

   a_deadline_sticky: assert property (@(posedge clock) disable iff (reset)
      dl_set_ff |=> dl_set_ff)
      else $error("deadline valid flag cleared outside reset");

   a_stats_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(sum_ff) && $stable(count_ff))
      else $error("interval statistics changed outside an update");

endmodule

// ===== rtl/adaptive_heartbeat_watchdog.sv =====
// A check or a rejected beat goes from evaluation straight to the result register;
// a first beat, or one with a saturated count, passes through square, update, scale
// and deadline; a beat that adds an interval also runs the serial multipliers, the
// restoring dividers and the root unit before its deviation is scaled.
// One item at a time: the next transfer can be taken in the cycle after the result is loaded.
// Reset is synchronous and active high and clears all statistics and the deadline.
module adaptive_heartbeat_watchdog #(
   parameter int INTERVAL_BITS = ahw_pkg::INTERVAL_BITS_DEF,
   parameter int COUNT_BITS    = ahw_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [ahw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ahw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [ahw_pkg::TIME_W-1:0]      req_time_now,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_rejected,
   output logic                            rsp_is_expired,
   output logic                            rsp_deadline_valid,
   output logic [ahw_pkg::TIME_W-1:0]      rsp_deadline_time,
   output logic [ahw_pkg::BEAT_W-1:0]      rsp_beat_count,
   output logic [ahw_pkg::STAT_W-1:0]      rsp_mean_interval,
   output logic [ahw_pkg::STAT_W-1:0]      rsp_interval_deviation
);
   import ahw_pkg::*;

   ahw_cmd_type    cmd;
   ahw_status_type status;

   ahw_ctrl #(
      .INTERVAL_BITS (INTERVAL_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ahw_datapath #(
      .INTERVAL_BITS (INTERVAL_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_action             (req_action),
      .req_time_now           (req_time_now),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_rejected           (rsp_rejected),
      .rsp_is_expired         (rsp_is_expired),
      .rsp_deadline_valid     (rsp_deadline_valid),
      .rsp_deadline_time      (rsp_deadline_time),
      .rsp_beat_count         (rsp_beat_count),
      .rsp_mean_interval      (rsp_mean_interval),
      .rsp_interval_deviation (rsp_interval_deviation),
      .cmd                    (cmd),
      .status                 (status)
   );

endmodule
